// ===== design/sal_pkg.sv =====
// shared constants, codes and control structs for the sorted linked list block
`default_nettype none

package sal_pkg;

    localparam int NODES    = 16;
    localparam int IDX_W    = $clog2(NODES);
    localparam int LINK_W   = $clog2(NODES + 1);
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int REM_W    = 5;
    localparam int SIZE_W   = 5;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED  = 2'd0;
    localparam t_status ST_DUPLICATE = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_REMOVED   = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    advance;
        logic    ins_node;
        logic    ins_link;
        logic    rm_pop;
        logic    rm_link;
        logic    load_out;
        t_status out_status;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic free_null;
        logic cur_null;
        logic cur_eq;
        logic cur_lt;
        logic cur_le_hi;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/sal_if.sv =====
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface sal_in_if
    import sal_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] upper;

    modport source (output valid, output kind, output value, output upper, input ready);
    modport sink   (input valid, input kind, input value, input upper, output ready);
endinterface

interface sal_out_if
    import sal_pkg::*;
();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [SLOT_W-1:0] slot;
    logic [REM_W-1:0]  removed_count;
    logic [SIZE_W-1:0] size;

    modport source (output valid, output status, output slot, output removed_count,
                    output size, input ready);
    modport sink   (input valid, input status, input slot, input removed_count,
                    input size, output ready);
endinterface

`default_nettype wire

// ===== design/sorted_array_linked_list_top.sv =====
// top level of the sorted linked list block: controller plus datapath
//
// Keeps an ascending, duplicate-free list of signed 32-bit values in a fixed
// pool of NODES nodes (value plus next link), with unused nodes chained on a
// free list. A request beat either inserts one value or removes every value
// in an inclusive range; each request gives exactly one result beat with a
// status, the node used by an insert, the number of nodes freed and the list
// size afterwards. Requests are handled one at a time. An insert walks the
// list one node per cycle up to its sorted position (or the matching value),
// then takes a node from the free list and links it in; an insert into a
// full list goes straight to its result. A removal walks to the lower bound,
// then frees one node per cycle, and links once at the end. The walk is set
// by the single read port on the link array, one node per cycle. A finished
// result sits in an output register, so the next request is taken while that
// beat still waits; a new result waits only if the previous one is not yet
// taken. No clearing pass is needed after reset.
`default_nettype none

module sorted_array_linked_list_top
    import sal_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    sal_in_if.sink    i_in,
    sal_out_if.source o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing and handshakes
    sal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // node storage, pointers and the result register
    sal_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_value         (i_in.value),
        .i_upper         (i_in.upper),
        .o_status        (o_out.status),
        .o_slot          (o_out.slot),
        .o_removed_count (o_out.removed_count),
        .o_size          (o_out.size)
    );

endmodule

`default_nettype wire

// ===== design/sal_dp.sv =====
// datapath: node arrays, list and free heads, walk pointers and result registers
`default_nettype none

module sal_dp
    import sal_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  wire signed [VAL_W-1:0]  i_value,
    input  wire signed [VAL_W-1:0]  i_upper,
    output t_status                 o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [REM_W-1:0]        o_removed_count,
    output logic [SIZE_W-1:0]       o_size
);

    logic signed [VAL_W-1:0] r_value [NODES];
    logic [LINK_W-1:0]       r_next  [NODES];
    logic [LINK_W-1:0]       r_head;
    logic [LINK_W-1:0]       r_free;
    logic [CNT_W-1:0]        r_count;
    logic [LINK_W-1:0]       r_cur;
    logic [LINK_W-1:0]       r_prev;
    logic [IDX_W-1:0]        r_node;
    logic [CNT_W-1:0]        r_rm;
    logic signed [VAL_W-1:0] r_v;
    logic signed [VAL_W-1:0] r_hi;

    t_status           r_o_status;
    logic [SLOT_W-1:0] r_o_slot;
    logic [REM_W-1:0]  r_o_removed;
    logic [SIZE_W-1:0] r_o_size;

    logic [IDX_W-1:0]        w_cur_idx;
    logic [IDX_W-1:0]        w_prev_idx;
    logic [IDX_W-1:0]        w_free_idx;
    logic [IDX_W-1:0]        w_rd_idx;
    logic [LINK_W-1:0]       w_next_rd;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_prev_null;

    assign w_cur_idx   = r_cur[IDX_W-1:0];
    assign w_prev_idx  = r_prev[IDX_W-1:0];
    assign w_free_idx  = r_free[IDX_W-1:0];
    // one link read a cycle: free head while taking a node, else the walk pointer
    assign w_rd_idx    = i_cmd.ins_node ? w_free_idx : w_cur_idx;
    assign w_next_rd   = r_next[w_rd_idx];
    assign w_val       = r_value[w_cur_idx];
    assign w_prev_null = (r_prev >= NIL);

    assign o_stat.free_null = (r_free >= NIL);
    assign o_stat.cur_null  = (r_cur >= NIL);
    assign o_stat.cur_eq    = (w_val == r_v);
    assign o_stat.cur_lt    = (w_val < r_v);
    assign o_stat.cur_le_hi = (w_val <= r_hi);

    // node values, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_node) begin
            r_value[w_free_idx] <= r_v;
        end
    end

    // link array, reset to a chain of all nodes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_next[i] <= LINK_W'(i + 1);
            end
        end else if (i_cmd.ins_node) begin
            r_next[w_free_idx] <= r_cur;
        end else if (i_cmd.ins_link && !w_prev_null) begin
            r_next[w_prev_idx] <= LINK_W'(r_node);
        end else if (i_cmd.rm_pop) begin
            r_next[w_cur_idx] <= r_free;
        end else if (i_cmd.rm_link && !w_prev_null) begin
            r_next[w_prev_idx] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NIL;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.ins_node) begin
                r_free <= w_next_rd;
            end else if (i_cmd.rm_pop) begin
                r_free <= r_cur;
            end
            if (i_cmd.ins_link) begin
                if (w_prev_null) begin
                    r_head <= LINK_W'(r_node);
                end
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.rm_link) begin
                if (w_prev_null) begin
                    r_head <= r_cur;
                end
                r_count <= r_count - r_rm;
            end
        end
    end

    // walk pointers and operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v    <= i_value;
            r_hi   <= i_upper;
            r_cur  <= r_head;
            r_prev <= NIL;
            r_rm   <= '0;
        end else if (i_cmd.advance) begin
            r_prev <= r_cur;
            r_cur  <= w_next_rd;
        end else if (i_cmd.rm_pop) begin
            r_cur <= w_next_rd;
            r_rm  <= r_rm + CNT_W'(1);
        end
        if (i_cmd.ins_node) begin
            r_node <= w_free_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status  <= i_cmd.out_status;
            r_o_slot    <= (i_cmd.out_status == ST_INSERTED) ? SLOT_W'(r_node) : '0;
            r_o_removed <= (i_cmd.out_status == ST_REMOVED) ? REM_W'(r_rm) : '0;
            r_o_size    <= SIZE_W'(r_count);
        end
    end

    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_removed_count = r_o_removed;
    assign o_size          = r_o_size;

endmodule

`default_nettype wire

// ===== design/sal_ctrl.sv =====
// controller: sequences walks and link updates, owns the handshakes
`default_nettype none

module sal_ctrl
    import sal_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_in_kind,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_WALK  = 3'd1;
    localparam logic [2:0] S_INS_NODE  = 3'd2;
    localparam logic [2:0] S_INS_LINK  = 3'd3;
    localparam logic [2:0] S_RM_SKIP   = 3'd4;
    localparam logic [2:0] S_RM_DEL    = 3'd5;
    localparam logic [2:0] S_RM_LINK   = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    logic [2:0] r_state, n_state;
    t_status    r_code, n_code;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_slot_free;

    // no request is taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.out_status = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_kind == KIND_REMOVE) begin
                        n_state = S_RM_SKIP;
                    end else if (i_stat.free_null) begin
                        n_code  = ST_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_INS_WALK;
                    end
                end
            end
            S_INS_WALK: begin
                if (!i_stat.cur_null && i_stat.cur_eq) begin
                    n_code  = ST_DUPLICATE;
                    n_state = S_RESP;
                end else if (i_stat.cur_null || !i_stat.cur_lt) begin
                    n_state = S_INS_NODE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_INS_NODE: begin
                o_cmd.ins_node = 1'b1;
                n_state        = S_INS_LINK;
            end
            S_INS_LINK: begin
                o_cmd.ins_link = 1'b1;
                n_code         = ST_INSERTED;
                n_state        = S_RESP;
            end
            S_RM_SKIP: begin
                if (i_stat.cur_null || !i_stat.cur_lt) begin
                    n_state = S_RM_DEL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_RM_DEL: begin
                if (!i_stat.cur_null && i_stat.cur_le_hi) begin
                    o_cmd.rm_pop = 1'b1;
                end else begin
                    n_state = S_RM_LINK;
                end
            end
            S_RM_LINK: begin
                o_cmd.rm_link = 1'b1;
                n_code        = ST_REMOVED;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
